// ===== hw/rtl/ukst_pkg.sv =====
// Shared definitions for the unique key set table.
// Field widths, operation and status codes, default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ukst_pkg;

  // Default sizes, overridable at the top level
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  // Fixed port field widths
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ADD       = 3'd0;
  localparam op_t OP_REMOVE    = 3'd1;
  localparam op_t OP_CONTAINS  = 3'd2;
  localparam op_t OP_REMOVE_AT = 3'd3;
  localparam op_t OP_READ_AT   = 3'd4;
  localparam op_t OP_CLEAR     = 3'd5;

  localparam status_t ST_DONE      = 3'd0;
  localparam status_t ST_PRESENT   = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_RANGE     = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/ukst_if.sv =====
// Valid/ready channel interfaces for the unique key set table.
// Command word in, result word out. Depends on ukst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ukst_cmd_if;
  import ukst_pkg::*;

  logic             valid;
  logic             ready;
  op_t              operation;
  logic [KEY_W-1:0] key;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output operation, output key, output slot_index,
                  input ready);
  modport sink   (input valid, input operation, input key, input slot_index,
                  output ready);
endinterface

interface ukst_rsp_if;
  import ukst_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic               hit;
  logic [SLOT_W-1:0]  found_slot;
  logic [KEY_W-1:0]   read_key;
  logic [COUNT_W-1:0] count_after;

  modport source (output valid, output status, output hit, output found_slot,
                  output read_key, output count_after, input ready);
  modport sink   (input valid, input status, input hit, input found_slot,
                  input read_key, input count_after, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ukst_mem.sv =====
// Key slot memory: one write port, one read port, registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ukst_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ukst_seq.sv =====
// Sequencer for the unique key set table: linear search, swap-and-pop,
// key count and result register. Depends on ukst_pkg and ukst_if.
`timescale 1ns / 1ps
`default_nettype none

module ukst_seq #(
  parameter int CAPACITY = ukst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ukst_pkg::KEY_BITS_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  ukst_cmd_if.sink                 cmd,
  ukst_rsp_if.source               rsp,
  output logic                     mem_wr_en,
  output logic      [AW-1:0]       mem_wr_addr,
  output logic      [KEY_BITS-1:0] mem_wr_data,
  output logic                     mem_rd_en,
  output logic      [AW-1:0]       mem_rd_addr,
  input  wire logic [KEY_BITS-1:0] mem_rd_data
);
  import ukst_pkg::*;

  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_ACT    = 3'd2;
  localparam logic [2:0] S_SWAP   = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]          state;
  op_t                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]    idx_q;
  logic [CW-1:0]       count;
  logic [CW-1:0]       issue_idx;
  logic                pend;
  logic [AW-1:0]       pend_idx;
  logic                found;
  logic [AW-1:0]       found_slot_q;
  logic [AW-1:0]       target;
  status_t             status_q;
  logic [KEY_W-1:0]    rkey_q;
  logic                out_valid;

  logic          issue_more;
  logic          idx_ok;
  logic          full;
  logic [CW-1:0] last;
  logic          target_lt_last;
  logic          rsp_load;

  assign issue_more     = issue_idx < count;
  assign idx_ok         = CMPW'(idx_q) < CMPW'(count);
  assign full           = count == CW'(CAPACITY);
  assign last           = count - CW'(1);
  assign target_lt_last = CW'(target) < last;
  assign rsp_load       = (state == S_RESULT) && (!out_valid || rsp.ready);

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;

  // Memory port control; at most one access per cycle, so no forwarding
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = key_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    unique case (state)
      S_SEARCH: begin
        mem_rd_en   = issue_more;
        mem_rd_addr = issue_idx[AW-1:0];
      end
      S_ACT: begin
        if (op_q == OP_ADD && !found && !full) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = count[AW-1:0];
        end
        if (op_q == OP_READ_AT && idx_ok) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(idx_q);
        end
      end
      S_SWAP: begin
        mem_rd_en   = target_lt_last;
        mem_rd_addr = last[AW-1:0];
      end
      S_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = target;
        mem_wr_data = mem_rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend     <= (state == S_SEARCH) && issue_more;
      pend_idx <= issue_idx[AW-1:0];
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_q      <= cmd.operation;
            key_q     <= KEY_BITS'(cmd.key);
            idx_q     <= cmd.slot_index;
            issue_idx <= '0;
            found     <= 1'b0;
            status_q  <= ST_DONE;
            rkey_q    <= '0;
            case (cmd.operation) inside
              OP_ADD, OP_REMOVE, OP_CONTAINS: state <= S_SEARCH;
              default:                        state <= S_ACT;
            endcase
          end
        end
        S_SEARCH: begin
          if (issue_more) begin
            issue_idx <= issue_idx + CW'(1);
          end
          // compare the word read last cycle; stop at first match or end
          if (pend && mem_rd_data == key_q) begin
            found        <= 1'b1;
            found_slot_q <= pend_idx;
            state        <= S_ACT;
          end else if (!pend && !issue_more) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          unique case (op_q)
            OP_ADD: begin
              state <= S_RESULT;
              if (found) begin
                status_q <= ST_PRESENT;
              end else if (full) begin
                status_q <= ST_FULL;
              end else begin
                count <= count + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (found) begin
                target <= found_slot_q;
                state  <= S_SWAP;
              end else begin
                status_q <= ST_NOT_FOUND;
                state    <= S_RESULT;
              end
            end
            OP_CONTAINS: begin
              state <= S_RESULT;
              if (!found) begin
                status_q <= ST_NOT_FOUND;
              end
            end
            OP_REMOVE_AT: begin
              if (idx_ok) begin
                target <= AW'(idx_q);
                state  <= S_SWAP;
              end else begin
                status_q <= ST_RANGE;
                state    <= S_RESULT;
              end
            end
            OP_READ_AT: begin
              if (idx_ok) begin
                state <= S_READ;
              end else begin
                status_q <= ST_RANGE;
                state    <= S_RESULT;
              end
            end
            OP_CLEAR: begin
              count <= '0;
              state <= S_RESULT;
            end
            default: state <= S_RESULT;
          endcase
        end
        S_SWAP: begin
          // move the last key into the hole unless the hole is the last slot
          if (target_lt_last) begin
            state <= S_MOVE;
          end else begin
            count <= last;
            state <= S_RESULT;
          end
        end
        S_MOVE: begin
          count <= last;
          state <= S_RESULT;
        end
        S_READ: begin
          rkey_q <= KEY_W'(mem_rd_data);
          state  <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_load) begin
            rsp.status      <= status_q;
            rsp.hit         <= found;
            rsp.found_slot  <= found ? SLOT_W'(found_slot_q) : '0;
            rsp.read_key    <= rkey_q;
            rsp.count_after <= COUNT_W'(count);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ast_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("key count above capacity");

  ast_one_access: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> !mem_rd_en)
    else $error("memory read and write in the same cycle");

  ast_move_pops: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |=> (count == $past(count) - CW'(1)))
    else $error("swap move did not pop the last key");

  ast_move_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (CW'(target) < count))
    else $error("swap target outside held keys");

  ast_hit_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && found) |-> (status_q == ST_DONE || status_q == ST_PRESENT))
    else $error("hit reported with a failing status");

endmodule

`default_nettype wire

// ===== hw/rtl/unique_key_set_table.sv =====
// Unique key set table: set of distinct keys held densely in slots
// 0 to count-1 of one memory. Depends on ukst_pkg, ukst_if, ukst_mem, ukst_seq.
//
// Usage:
//   cmd carries one command word (operation, key, slot_index); rsp returns
//   exactly one result word (status, hit, found_slot, read_key, count_after)
//   per command, in order. Both are valid/ready channels.
//   Add, remove and contains scan the held keys through the single memory
//   read port, one slot per cycle, stopping at the first match. A remove
//   then passes through a swap state, and also a move state when the last
//   key moves into the hole. One command is worked at a time; cmd.ready is
//   high while the sequencer is idle, from the cycle after a result is
//   loaded, and the next command is taken while a result waits in the
//   output register.
//   Reset sets the key count to zero and empties the output register; the
//   memory itself is not cleared, since only slots below count are read.
//   If rsp stalls, the finished result holds; the following command runs
//   until its own result needs the output register, then waits.
`timescale 1ns / 1ps
`default_nettype none

module unique_key_set_table #(
  parameter int CAPACITY = ukst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ukst_pkg::KEY_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  ukst_cmd_if.sink   cmd,
  ukst_rsp_if.source rsp
);
  import ukst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_data;

  ukst_seq #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rsp         (rsp),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data)
  );

  ukst_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
